/* src/ipv6rf_pkg.sv */
// Package for the IPv6 receive filter: verdict and match codes, header constants,
// and the frame snapshot and result structures shared by the filter modules.
// Depends on nothing.
package ipv6rf_pkg;

  localparam int unsigned CountW = 17;
  localparam int unsigned LenW   = CountW + 1;

  localparam logic [CountW-1:0] COUNT_MAX    = '1;
  localparam logic [LenW-1:0]   HDR_LEN      = LenW'(40);
  localparam logic [15:0]       ICMP_HDR_LEN = 16'd4;
  localparam logic [15:0]       NS_MIN_LEN   = 16'd24;
  localparam logic [7:0]        NH_ICMPV6    = 8'd58;
  localparam logic [7:0]        TYPE_NS      = 8'd135;
  localparam logic [3:0]        IP_VERSION   = 4'h6;
  localparam logic [63:0]       LL_PREFIX    = 64'hFE80_0000_0000_0000;
  localparam logic [63:0]       MC_PREFIX    = 64'hFF02_0000_0000_0000;
  localparam logic [63:0]       ALL_NODES_LO = 64'h0000_0000_0000_0001;
  localparam logic [15:0]       SOL_NODE_TAG = 16'h01FF;

  // Configuration register indexes.
  localparam logic [2:0] CFG_OUR_HI   = 3'd0;
  localparam logic [2:0] CFG_OUR_LO   = 3'd1;
  localparam logic [2:0] CFG_PEER_HI  = 3'd2;
  localparam logic [2:0] CFG_PEER_LO  = 3'd3;
  localparam logic [2:0] CFG_DATA_NH  = 3'd4;

  typedef enum logic [2:0] {
    V_DELIVER     = 3'd0,
    V_ADVERTISE   = 3'd1,
    V_IGNORE      = 3'd2,
    V_OVERFLOW    = 3'd3,
    V_BAD_VERSION = 3'd4
  } verdict_e;

  typedef enum logic [2:0] {
    M_NONE       = 3'd0,
    M_UNICAST    = 3'd1,
    M_ALL_NODES  = 3'd2,
    M_SOLICITED  = 3'd3,
    M_LINK_LOCAL = 3'd4
  } match_e;

  // Header fields of a complete frame, as they stand after its last byte.
  typedef struct packed {
    logic [LenW-1:0] len;
    logic [3:0]      version;
    logic [15:0]     plen;
    logic [7:0]      next_header;
    logic [127:0]    source;
    logic [127:0]    dest;
    logic [7:0]      icmp_type;
    logic [1:0]      target_flags;  // bit 0 unicast, bit 1 link-local
  } frame_t;

  typedef struct packed {
    verdict_e     verdict;
    logic [15:0]  payload_length;
    match_e       match_kind;
    logic         target_link_local;
    logic         reply_to_all_nodes;
    logic [127:0] source;
  } result_t;

endpackage

/* src/ipv6rf_if.sv */
// Handshake interfaces for the frame byte stream and the verdict stream.
// Depends on nothing; payload widths follow the filter's field list.
interface ipv6rf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink (input valid, data_byte, last_byte, output ready);
endinterface

interface ipv6rf_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  verdict;
  logic [15:0] payload_length;
  logic [2:0]  match_kind;
  logic        target_link_local;
  logic        reply_to_all_nodes;
  logic [63:0] source_hi;
  logic [63:0] source_lo;

  modport source (output valid, verdict, payload_length, match_kind, target_link_local,
                  reply_to_all_nodes, source_hi, source_lo, input ready);
  modport sink (input valid, verdict, payload_length, match_kind, target_link_local,
                reply_to_all_nodes, source_hi, source_lo, output ready);
endinterface

/* src/ipv6rf_parse.sv */
// Per-frame header capture: byte counter, header fields and target match flags.
// Depends on ipv6rf_pkg; presents the frame as it stands after the current byte.
module ipv6rf_parse (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic                 last_i,
  input  logic [7:0]           byte_i,
  input  logic [63:0]          our_addr_hi_i,
  input  logic [63:0]          our_addr_lo_i,
  output ipv6rf_pkg::frame_t   frame_o
);
  import ipv6rf_pkg::*;

  logic [CountW-1:0] count_q, count_d;
  frame_t            frm_q, frm_d;
  frame_t            frm_clear;
  logic [127:0]      uni_addr, ll_addr;
  logic [3:0]        tgt_idx;
  logic [6:0]        tgt_bit;
  logic [7:0]        uni_byte, ll_byte;

  assign uni_addr = {our_addr_hi_i, our_addr_lo_i};
  assign ll_addr  = {LL_PREFIX, our_addr_lo_i};
  // Target bytes 48..63 map to address bytes 0..15, most significant first.
  assign tgt_idx  = 4'd15 - count_q[3:0];
  assign tgt_bit  = {tgt_idx, 3'b000};
  assign uni_byte = uni_addr[tgt_bit +: 8];
  assign ll_byte  = ll_addr[tgt_bit +: 8];

  always_comb begin
    frm_clear              = '0;
    frm_clear.target_flags = 2'b11;
  end

  always_comb begin
    frm_d     = frm_q;
    frm_d.len = {1'b0, count_q} + LenW'(1);
    count_d   = (count_q == COUNT_MAX) ? count_q : count_q + CountW'(1);
    if (count_q == CountW'(0)) begin
      frm_d.version = byte_i[7:4];
    end else if (count_q == CountW'(4)) begin
      frm_d.plen[15:8] = byte_i;
    end else if (count_q == CountW'(5)) begin
      frm_d.plen[7:0] = byte_i;
    end else if (count_q == CountW'(6)) begin
      frm_d.next_header = byte_i;
    end else if (count_q >= CountW'(8) && count_q < CountW'(24)) begin
      frm_d.source = {frm_q.source[119:0], byte_i};
    end else if (count_q >= CountW'(24) && count_q < CountW'(40)) begin
      frm_d.dest = {frm_q.dest[119:0], byte_i};
    end else if (count_q == CountW'(40)) begin
      frm_d.icmp_type = byte_i;
    end else if (count_q >= CountW'(48) && count_q < CountW'(64)) begin
      if (byte_i != uni_byte) frm_d.target_flags[0] = 1'b0;
      if (byte_i != ll_byte)  frm_d.target_flags[1] = 1'b0;
    end
  end

  assign frame_o = frm_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      frm_q   <= frm_clear;
    end else if (accept_i) begin
      if (last_i) begin
        count_q <= '0;
        frm_q   <= frm_clear;
      end else begin
        count_q <= count_d;
        frm_q   <= frm_d;
      end
    end
  end

endmodule

/* src/ipv6rf_decide.sv */
// Verdict logic: length and version checks, destination and peer matching.
// Depends on ipv6rf_pkg; purely combinational, fed by a registered frame snapshot.
module ipv6rf_decide (
  input  ipv6rf_pkg::frame_t  frame_i,
  input  logic [63:0]         our_addr_hi_i,
  input  logic [63:0]         our_addr_lo_i,
  input  logic [63:0]         peer_addr_hi_i,
  input  logic [63:0]         peer_addr_lo_i,
  input  logic [7:0]          data_next_header_i,
  output ipv6rf_pkg::result_t result_o
);
  import ipv6rf_pkg::*;

  logic [63:0]     dh, dl;
  match_e          kind;
  logic            short_frame, plen_too_big, peer_match;
  logic [LenW-1:0] room;

  assign dh = frame_i.dest[127:64];
  assign dl = frame_i.dest[63:0];

  always_comb begin
    kind = M_NONE;
    if (dh == our_addr_hi_i && dl == our_addr_lo_i) begin
      kind = M_UNICAST;
    end else if (dh == LL_PREFIX && dl == our_addr_lo_i) begin
      kind = M_LINK_LOCAL;
    end else if (dh == MC_PREFIX && dl == ALL_NODES_LO) begin
      kind = M_ALL_NODES;
    end else if (dh == MC_PREFIX && dl == {24'h0, SOL_NODE_TAG, our_addr_lo_i[23:0]}) begin
      kind = M_SOLICITED;
    end
  end

  assign short_frame  = frame_i.len < HDR_LEN;
  assign room         = frame_i.len - HDR_LEN;
  assign plen_too_big = {2'b00, frame_i.plen} > room;
  assign peer_match   = frame_i.source == {peer_addr_hi_i, peer_addr_lo_i} &&
                        frame_i.dest == {our_addr_hi_i, our_addr_lo_i};

  always_comb begin
    result_o         = '0;
    result_o.verdict = V_IGNORE;
    if (short_frame) begin
      result_o.verdict = V_OVERFLOW;
    end else if (frame_i.version != IP_VERSION) begin
      result_o.verdict = V_BAD_VERSION;
    end else if (plen_too_big) begin
      result_o.verdict = V_OVERFLOW;
    end else if (frame_i.next_header == NH_ICMPV6) begin
      if (frame_i.plen < ICMP_HDR_LEN) begin
        result_o.verdict = V_OVERFLOW;
      end else if (frame_i.icmp_type == TYPE_NS) begin
        if (kind == M_NONE) begin
          result_o.verdict = V_IGNORE;
        end else if (frame_i.plen < NS_MIN_LEN) begin
          result_o.verdict = V_OVERFLOW;
        end else if (frame_i.target_flags == 2'b00) begin
          result_o.verdict = V_IGNORE;
        end else begin
          result_o.verdict            = V_ADVERTISE;
          result_o.match_kind         = kind;
          result_o.target_link_local  = frame_i.target_flags[1];
          result_o.reply_to_all_nodes = (frame_i.source == '0);
          result_o.source             = frame_i.source;
        end
      end
    end else if (frame_i.next_header == data_next_header_i && peer_match) begin
      result_o.verdict        = V_DELIVER;
      result_o.payload_length = frame_i.plen;
      result_o.source         = frame_i.source;
    end
  end

endmodule

/* src/ipv6_receive_filter.sv */
// IPv6 receive filter top level. One frame byte per ready cycle, no gaps required.
// The verdict goes through the snapshot register, then the verdict register, to out_o.
// One byte per clock while ready; a frame may start right after the previous last byte.
// Reset (rst_ni, asynchronous, active low) clears the byte counter, both pipeline valid
// flags and the configuration registers; the target match flags come up set.
// Depends on ipv6rf_pkg, ipv6rf_if, ipv6rf_parse and ipv6rf_decide.
module ipv6_receive_filter (
  input  logic                clk_i,
  input  logic                rst_ni,
  ipv6rf_in_if.sink           in_i,
  ipv6rf_out_if.source        out_o,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [63:0]         cfg_data_i
);
  import ipv6rf_pkg::*;

  // Cfg regs. The host must write them only while no verdict is pending; unenforced.
  logic [63:0] our_hi_q, our_lo_q, peer_hi_q, peer_lo_q;
  logic [7:0]  data_nh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      our_hi_q  <= '0;
      our_lo_q  <= '0;
      peer_hi_q <= '0;
      peer_lo_q <= '0;
      data_nh_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_OUR_HI:  our_hi_q  <= cfg_data_i;
        CFG_OUR_LO:  our_lo_q  <= cfg_data_i;
        CFG_PEER_HI: peer_hi_q <= cfg_data_i;
        CFG_PEER_LO: peer_lo_q <= cfg_data_i;
        CFG_DATA_NH: data_nh_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Pipeline control. Stage one holds the snapshot of a finished frame, stage two the
  // registered verdict. A stage advances when the stage after it is empty or draining,
  // so bytes flow while a verdict waits for the consumer, until a snapshot waits too.
  logic    snap_valid_q, snap_valid_d;
  logic    out_valid_q, out_valid_d;
  logic    out_free, snap_free, in_fire, in_last;
  frame_t  frame_now, snap_q;
  result_t result_now, result_q;

  assign out_free  = !out_valid_q || out_o.ready;
  assign snap_free = !snap_valid_q || out_free;
  assign in_i.ready = snap_free;
  assign in_fire   = in_i.valid && snap_free;
  assign in_last   = in_fire && in_i.last_byte;

  assign snap_valid_d = in_last || (snap_valid_q && !out_free);
  assign out_valid_d  = (snap_valid_q && out_free) || (out_valid_q && !out_o.ready);

  // Header capture runs on every accepted beat and clears itself after the last one.
  ipv6rf_parse u_parse (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (in_fire),
    .last_i        (in_i.last_byte),
    .byte_i        (in_i.data_byte),
    .our_addr_hi_i (our_hi_q),
    .our_addr_lo_i (our_lo_q),
    .frame_o       (frame_now)
  );

  // The verdict is worked out from the snapshot, so the next frame can already fill
  // the capture registers while this one is judged.
  ipv6rf_decide u_decide (
    .frame_i            (snap_q),
    .our_addr_hi_i      (our_hi_q),
    .our_addr_lo_i      (our_lo_q),
    .peer_addr_hi_i     (peer_hi_q),
    .peer_addr_lo_i     (peer_lo_q),
    .data_next_header_i (data_nh_q),
    .result_o           (result_now)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      snap_valid_q <= snap_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers load only on a transfer and need no reset.
  always_ff @(posedge clk_i) begin
    if (in_last) snap_q <= frame_now;
    if (snap_valid_q && out_free) result_q <= result_now;
  end

  assign out_o.valid              = out_valid_q;
  assign out_o.verdict            = result_q.verdict;
  assign out_o.payload_length     = result_q.payload_length;
  assign out_o.match_kind         = result_q.match_kind;
  assign out_o.target_link_local  = result_q.target_link_local;
  assign out_o.reply_to_all_nodes = result_q.reply_to_all_nodes;
  assign out_o.source_hi          = result_q.source[127:64];
  assign out_o.source_lo          = result_q.source[63:0];

  // A last byte always leaves a snapshot behind for the verdict stage.
  a_last_fills_snap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_last |=> snap_valid_q)
    else $error("last beat did not load the frame snapshot");

  // A snapshot that cannot move on must still be there next cycle.
  a_snap_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    snap_valid_q && !out_free |=> snap_valid_q)
    else $error("frame snapshot lost while the output was stalled");

  // A snapshot that moves on turns into a visible verdict.
  a_snap_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    snap_valid_q && out_free |=> out_valid_q)
    else $error("snapshot advanced without producing a verdict");

  // Only delivered frames carry a payload length.
  a_plen_only_deliver: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && result_q.verdict != V_DELIVER |-> result_q.payload_length == '0)
    else $error("payload length set on a frame that is not delivered");

  // Solicitation details appear only with an advertisement request.
  a_ns_fields_only_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && result_q.verdict != V_ADVERTISE |->
      result_q.match_kind == M_NONE && !result_q.target_link_local &&
      !result_q.reply_to_all_nodes)
    else $error("solicitation fields set without an advertisement verdict");

endmodule

/* dv/ipv6rf_checker.sv */
// Scoreboard for the IPv6 receive filter: follows every byte beat and register write,
// works out the verdict of each frame and compares it with the verdict beats.
// Depends on ipv6rf_pkg and ipv6rf_if.
module ipv6rf_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  ipv6rf_in_if        in_b,
  ipv6rf_out_if       out_b,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  output int unsigned errors_o,
  output int unsigned waiting_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import ipv6rf_pkg::*;

  // Register copies.
  logic [63:0] our_hi, our_lo, peer_hi, peer_lo;
  logic [7:0]  data_nh;

  // Per-frame header state.
  logic [CountW-1:0] byte_cnt;
  logic [3:0]        ver_nib;
  logic [15:0]       hdr_plen;
  logic [7:0]        hdr_nh;
  logic [127:0]      pkt_src, pkt_dst;
  logic [7:0]        icmp_ty;
  logic [1:0]        tgt_match;  // bit 0 unicast, bit 1 link-local

  result_t     verdicts_due[$];
  int unsigned err_count = 0;

  assign errors_o = err_count;

  task automatic clear_frame_state();
    byte_cnt  = '0;
    ver_nib   = '0;
    hdr_plen  = '0;
    hdr_nh    = '0;
    pkt_src   = '0;
    pkt_dst   = '0;
    icmp_ty   = '0;
    tgt_match = 2'b11;
  endtask

  function automatic match_e classify_dest();
    logic [63:0] dh, dl;
    dh = pkt_dst[127:64];
    dl = pkt_dst[63:0];
    if (dh == our_hi && dl == our_lo) return M_UNICAST;
    if (dh == LL_PREFIX && dl == our_lo) return M_LINK_LOCAL;
    if (dh == MC_PREFIX && dl[63:40] == '0) begin
      if (dl == ALL_NODES_LO) return M_ALL_NODES;
      if (dl[39:0] == {SOL_NODE_TAG, our_lo[23:0]}) return M_SOLICITED;
    end
    return M_NONE;
  endfunction

  // Takes one byte of the frame; on the last one queues the verdict it must produce.
  task automatic absorb_byte(input logic [7:0] b, input logic is_last);
    int unsigned     k, i;
    logic [LenW-1:0] len;
    logic [127:0]    uni_tgt, ll_tgt;
    match_e          kind;
    result_t         r;
    k       = byte_cnt;
    uni_tgt = {our_hi, our_lo};
    ll_tgt  = {LL_PREFIX, our_lo};
    if (k == 0) ver_nib = b[7:4];
    else if (k == 4) hdr_plen[15:8] = b;
    else if (k == 5) hdr_plen[7:0] = b;
    else if (k == 6) hdr_nh = b;
    else if (k >= 8 && k < 24) pkt_src[127 - 8 * (k - 8) -: 8] = b;
    else if (k >= 24 && k < 40) pkt_dst[127 - 8 * (k - 24) -: 8] = b;
    else if (k == 40) icmp_ty = b;
    else if (k >= 48 && k < 64) begin
      i = k - 48;
      if (b != uni_tgt[127 - 8 * i -: 8]) tgt_match[0] = 1'b0;
      if (b != ll_tgt[127 - 8 * i -: 8]) tgt_match[1] = 1'b0;
    end
    len = LenW'(byte_cnt) + 1'b1;
    if (byte_cnt != COUNT_MAX) byte_cnt = byte_cnt + 1'b1;
    if (!is_last) return;

    r.verdict            = V_IGNORE;
    r.payload_length     = '0;
    r.match_kind         = M_NONE;
    r.target_link_local  = 1'b0;
    r.reply_to_all_nodes = 1'b0;
    r.source             = '0;
    if (len < HDR_LEN) begin
      r.verdict = V_OVERFLOW;
    end else if (ver_nib != IP_VERSION) begin
      r.verdict = V_BAD_VERSION;
    end else if (LenW'(hdr_plen) > len - HDR_LEN) begin
      r.verdict = V_OVERFLOW;
    end else if (hdr_nh == NH_ICMPV6) begin
      if (hdr_plen < ICMP_HDR_LEN) begin
        r.verdict = V_OVERFLOW;
      end else if (icmp_ty == TYPE_NS) begin
        kind = classify_dest();
        if (kind == M_NONE) begin
          r.verdict = V_IGNORE;
        end else if (hdr_plen < NS_MIN_LEN) begin
          r.verdict = V_OVERFLOW;
        end else if (tgt_match == 2'b00) begin
          r.verdict = V_IGNORE;
        end else begin
          r.verdict            = V_ADVERTISE;
          r.match_kind         = kind;
          r.target_link_local  = tgt_match[1];
          r.reply_to_all_nodes = (pkt_src == '0);
          r.source             = pkt_src;
        end
      end
    end else if (hdr_nh == data_nh && pkt_src == {peer_hi, peer_lo} &&
                 pkt_dst == {our_hi, our_lo}) begin
      r.verdict        = V_DELIVER;
      r.payload_length = hdr_plen;
      r.source         = pkt_src;
    end
    verdicts_due.push_back(r);
    clear_frame_state();
  endtask

  function automatic void check_field(input string what, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      err_count++;
      if (err_count <= 50)
        $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
    end
  endfunction

  task automatic compare_verdict();
    result_t want;
    if (verdicts_due.size() == 0) begin
      err_count++;
      if (err_count <= 50)
        $display("%0t: verdict beat %0d with none outstanding, expected nothing, source %h_%h",
                 $time, out_b.verdict, out_b.source_hi, out_b.source_lo);
      return;
    end
    want = verdicts_due.pop_front();
    check_field("verdict", 64'(want.verdict), 64'(out_b.verdict));
    check_field("payload_length", 64'(want.payload_length), 64'(out_b.payload_length));
    check_field("match_kind", 64'(want.match_kind), 64'(out_b.match_kind));
    check_field("target_link_local", 64'(want.target_link_local),
                64'(out_b.target_link_local));
    check_field("reply_to_all_nodes", 64'(want.reply_to_all_nodes),
                64'(out_b.reply_to_all_nodes));
    check_field("source_hi", want.source[127:64], out_b.source_hi);
    check_field("source_lo", want.source[63:0], out_b.source_lo);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      our_hi  = '0;
      our_lo  = '0;
      peer_hi = '0;
      peer_lo = '0;
      data_nh = '0;
      clear_frame_state();
      verdicts_due.delete();
      waiting_o <= 0;
    end else begin
      if (out_b.valid && out_b.ready) compare_verdict();
      if (in_b.valid && in_b.ready) absorb_byte(in_b.data_byte, in_b.last_byte);
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_OUR_HI:  our_hi = cfg_data_i;
          CFG_OUR_LO:  our_lo = cfg_data_i;
          CFG_PEER_HI: peer_hi = cfg_data_i;
          CFG_PEER_LO: peer_lo = cfg_data_i;
          CFG_DATA_NH: data_nh = cfg_data_i[7:0];
          default: ;
        endcase
      end
      waiting_o <= verdicts_due.size();
    end
  end

endmodule

/* dv/tb_top.sv */
// Top of the IPv6 receive filter testbench: clock, reset, frame stimulus, register
// programming, the verdict receiver and the final verdict of the run.
// Depends on ipv6rf_pkg, ipv6rf_if, ipv6_receive_filter and ipv6rf_checker.
module tb_top ();
  timeunit 1ns;
  timeprecision 1ps;

  import ipv6rf_pkg::*;

  // Cycles without any beat or register write before the run is declared hung. The
  // slowest legal stretch is a receiver stall at 51 percent idling plus a drain pause.
  localparam int unsigned StallLimit  = 10000;
  // Extra wait after every outstanding verdict has been taken, to be safe.
  localparam int unsigned DrainCycles = 8;
  // Next header values used as plain traffic, and an ICMPv6 type that is not a
  // neighbor solicitation.
  localparam logic [7:0]  NhTcp       = 8'd6;
  localparam logic [7:0]  TypeEcho    = 8'd128;
  // Byte beats of random traffic in each idling phase, on top of the directed frames.
  localparam int unsigned PhaseBeats  = 30;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i;
  logic [2:0]  cfg_index_i;
  logic [63:0] cfg_data_i;

  ipv6rf_in_if  in_b ();
  ipv6rf_out_if out_b ();

  int unsigned mismatches;
  int unsigned verdicts_waiting;

  // Idle rates in percent for the byte sender and the verdict receiver.
  int unsigned tx_idle_pct = 10;
  int unsigned rx_idle_pct = 51;

  // What the registers currently hold, so that frames can be aimed at them.
  logic [63:0] our_hi, our_lo, peer_hi, peer_lo;
  logic [7:0]  data_nh;

  int unsigned frames_sent   = 0;
  int unsigned beats_sent    = 0;
  int unsigned longest_frame = 0;
  int unsigned settings_used = 0;
  int unsigned verdicts_seen = 0;
  int unsigned stall_cycles  = 0;

  logic [7:0] frame_q[$];

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  ipv6_receive_filter u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_b),
    .out_o       (out_b),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  ipv6rf_checker u_chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_b        (in_b),
    .out_b       (out_b),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .errors_o    (mismatches),
    .waiting_o   (verdicts_waiting)
  );

  // The receiver drops ready at random, at the rate of the current phase.
  always @(posedge clk_i) begin
    out_b.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Watchdog: any beat on either channel or any register write counts as progress.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_b.valid && out_b.ready) verdicts_seen++;
      if ((in_b.valid && in_b.ready) || (out_b.valid && out_b.ready) || cfg_we_i) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= StallLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [127:0] rand128();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  // A near miss: the address with one random bit turned over.
  function automatic logic [127:0] flip_bit(input logic [127:0] a);
    return a ^ (128'd1 << $urandom_range(127));
  endfunction

  function automatic logic [127:0] our_unicast();
    return {our_hi, our_lo};
  endfunction

  function automatic logic [127:0] our_link_local();
    return {LL_PREFIX, our_lo};
  endfunction

  function automatic logic [127:0] all_nodes();
    return {MC_PREFIX, ALL_NODES_LO};
  endfunction

  function automatic logic [127:0] solicited_node();
    return {MC_PREFIX, 24'h0, SOL_NODE_TAG, our_lo[23:0]};
  endfunction

  function automatic logic [127:0] peer_addr();
    return {peer_hi, peer_lo};
  endfunction

  task automatic push_random(input int unsigned n);
    repeat (n) frame_q.push_back(8'($urandom));
  endtask

  task automatic push_addr(input logic [127:0] a);
    for (int j = 0; j < 16; j++) frame_q.push_back(a[127 - 8 * j -: 8]);
  endtask

  // Starts a new frame with a 40-byte IPv6 header. Traffic class, flow label and hop
  // limit carry random values, since the filter must not look at them.
  task automatic start_header(input logic [3:0] ver, input logic [15:0] plen,
                              input logic [7:0] nh, input logic [127:0] src,
                              input logic [127:0] dst);
    frame_q.delete();
    frame_q.push_back({ver, 4'($urandom)});
    push_random(3);
    frame_q.push_back(plen[15:8]);
    frame_q.push_back(plen[7:0]);
    frame_q.push_back(nh);
    push_random(1);
    push_addr(src);
    push_addr(dst);
  endtask

  task automatic build_data(input logic [3:0] ver, input logic [127:0] src,
                            input logic [127:0] dst, input logic [7:0] nh,
                            input logic [15:0] plen, input int unsigned n);
    start_header(ver, plen, nh, src, dst);
    push_random(n);
  endtask

  // Neighbor solicitation: type, code, checksum, reserved word, then the target at
  // frame offset 48, then extra option bytes.
  task automatic build_ns(input logic [127:0] src, input logic [127:0] dst,
                          input logic [127:0] tgt, input logic [15:0] plen,
                          input int unsigned extra);
    start_header(IP_VERSION, plen, NH_ICMPV6, src, dst);
    frame_q.push_back(TYPE_NS);
    push_random(7);
    push_addr(tgt);
    push_random(extra);
  endtask

  // One byte beat. While the sender idles it leaves junk on the payload so that the
  // filter is seen to ignore everything without valid.
  task automatic send_beat(input logic [7:0] b, input logic is_last);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_b.valid     <= 1'b0;
      in_b.data_byte <= 8'($urandom);
      in_b.last_byte <= 1'($urandom);
      @(posedge clk_i);
    end
    in_b.valid     <= 1'b1;
    in_b.data_byte <= b;
    in_b.last_byte <= is_last;
    do @(posedge clk_i); while (in_b.ready !== 1'b1);
  endtask

  task automatic send_frame();
    int unsigned n;
    n = frame_q.size();
    for (int unsigned j = 0; j < n; j++) send_beat(frame_q[j], j == n - 1);
    frames_sent++;
    beats_sent += n;
    if (n > longest_frame) longest_frame = n;
  endtask

  // Holds the sender back until every outstanding verdict has been taken, then lets
  // the pipeline run empty. The scoreboard count is registered, hence the first wait.
  task automatic settle();
    in_b.valid <= 1'b0;
    @(posedge clk_i);
    while (verdicts_waiting != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Each write sets enable, index and data for a clock edge; enable drops after the last.
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [63:0] hi, input logic [63:0] lo,
                              input logic [63:0] phi, input logic [63:0] plo,
                              input logic [7:0] nh);
    our_hi  = hi;
    our_lo  = lo;
    peer_hi = phi;
    peer_lo = plo;
    data_nh = nh;
    write_reg(CFG_OUR_HI, hi);
    write_reg(CFG_OUR_LO, lo);
    write_reg(CFG_PEER_HI, phi);
    write_reg(CFG_PEER_LO, plo);
    write_reg(CFG_DATA_NH, {56'h0, nh});
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  // New register setting, with all-zero and all-one addresses and the corner next
  // header values turning up often, and sometimes a unicast equal to link-local.
  task automatic pick_setting();
    logic [63:0] hi, lo, phi, plo;
    logic [7:0]  nh;
    hi  = rand64();
    lo  = rand64();
    phi = rand64();
    plo = rand64();
    nh  = 8'($urandom);
    case ($urandom_range(4))
      0: begin
        hi  = '0;
        lo  = '0;
        phi = '0;
        plo = '0;
      end
      1: begin
        hi  = '1;
        lo  = '1;
        phi = '1;
        plo = '1;
      end
      2: hi = LL_PREFIX;  // unicast and link-local address coincide
      default: ;
    endcase
    case ($urandom_range(4))
      0: nh = NH_ICMPV6;
      1: nh = '0;
      2: nh = '1;
      default: ;
    endcase
    program_regs(hi, lo, phi, plo, nh);
  endtask

  // Data traffic, mostly from the peer to us, with the occasional wrong address,
  // wrong next header, wrong version or payload length beyond the frame.
  task automatic make_data_frame();
    logic [127:0] src, dst;
    logic [7:0]   nh;
    logic [3:0]   ver;
    logic [15:0]  plen;
    int unsigned  n;
    src = peer_addr();
    dst = our_unicast();
    nh  = data_nh;
    ver = IP_VERSION;
    if ($urandom_range(7) == 0) src = $urandom_range(1) ? flip_bit(src) : rand128();
    if ($urandom_range(7) == 0) dst = $urandom_range(1) ? flip_bit(dst) : rand128();
    if ($urandom_range(7) == 0) nh = 8'($urandom);
    if ($urandom_range(9) == 0) ver = 4'($urandom);
    n = $urandom_range(24);
    case ($urandom_range(9))
      0: plen = 16'(n + 1 + $urandom_range(3));
      1: plen = 16'($urandom);
      default: plen = 16'($urandom_range(n));
    endcase
    build_data(ver, src, dst, nh, plen, n);
  endtask

  // Solicitations to each of our destination kinds and to near misses, with targets
  // that match one, both or neither of our addresses.
  task automatic make_ns_frame();
    logic [127:0] src, dst, tgt;
    logic [15:0]  plen;
    int unsigned  n;
    case ($urandom_range(5))
      0: dst = our_unicast();
      1: dst = our_link_local();
      2: dst = all_nodes();
      3: dst = solicited_node();
      4: dst = flip_bit(solicited_node());
      default: dst = rand128();
    endcase
    case ($urandom_range(3))
      0: src = '0;
      1: src = peer_addr();
      default: src = rand128();
    endcase
    case ($urandom_range(5))
      0, 1: tgt = our_unicast();
      2: tgt = our_link_local();
      3: tgt = flip_bit(our_unicast());
      4: tgt = flip_bit(our_link_local());
      default: tgt = rand128();
    endcase
    n = 24 + $urandom_range(16);
    case ($urandom_range(9))
      0: plen = 16'($urandom_range(23));
      1: plen = 16'(n + 1 + $urandom_range(7));
      default: plen = 16'($urandom_range(n, 24));
    endcase
    build_ns(src, dst, tgt, plen, n - 24);
  endtask

  // ICMPv6 that is not a well-formed solicitation: other types, or too short.
  task automatic make_icmp_frame();
    int unsigned n;
    n = $urandom_range(8);
    start_header(IP_VERSION, 16'($urandom_range(n)), NH_ICMPV6, rand128(), our_unicast());
    push_random(n);
    if (n > 0 && $urandom_range(1) == 0) frame_q[40] = TYPE_NS;
  endtask

  initial begin
    in_b.valid     = 1'b0;
    in_b.data_byte = '0;
    in_b.last_byte = 1'b0;
    out_b.ready    = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_index_i    = CFG_OUR_HI;
    cfg_data_i     = '0;
    our_hi         = '0;
    our_lo         = '0;
    peer_hi        = '0;
    peer_lo        = '0;
    data_nh        = '0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // With the reset register values every address is zero and data traffic has next
    // header zero, so an all-zero header frame is delivered.
    build_data(IP_VERSION, '0, '0, '0, '0, 0);
    send_frame();
    // A frame of a single byte.
    frame_q.delete();
    frame_q.push_back(8'hFF);
    send_frame();

    settle();
    program_regs(rand64(), rand64(), rand64(), rand64(), NhTcp);

    // Data traffic: empty and full payloads, a 39-byte frame, a bad version that also
    // has an oversized length (the version wins), a length beyond the frame, and each
    // of source, destination and next header wrong.
    build_data(IP_VERSION, peer_addr(), our_unicast(), data_nh, 16'd0, 0);
    send_frame();
    build_data(IP_VERSION, peer_addr(), our_unicast(), data_nh, 16'd20, 20);
    send_frame();
    build_data(IP_VERSION, peer_addr(), our_unicast(), data_nh, 16'd0, 0);
    void'(frame_q.pop_back());
    send_frame();
    build_data(4'h4, peer_addr(), our_unicast(), data_nh, 16'hFFFF, 3);
    send_frame();
    build_data(IP_VERSION, peer_addr(), our_unicast(), data_nh, 16'd9, 8);
    send_frame();
    build_data(IP_VERSION, flip_bit(peer_addr()), our_unicast(), data_nh, 16'd4, 4);
    send_frame();
    build_data(IP_VERSION, peer_addr(), flip_bit(our_unicast()), data_nh, 16'd4, 4);
    send_frame();
    build_data(IP_VERSION, peer_addr(), our_unicast(), data_nh ^ 8'h80, 16'd4, 4);
    send_frame();

    // ICMPv6 shorter than its own header, and an echo request.
    start_header(IP_VERSION, 16'd3, NH_ICMPV6, peer_addr(), our_unicast());
    frame_q.push_back(TYPE_NS);
    push_random(2);
    send_frame();
    start_header(IP_VERSION, 16'd8, NH_ICMPV6, peer_addr(), our_unicast());
    frame_q.push_back(TypeEcho);
    push_random(7);
    send_frame();

    // Solicitations to each destination kind, then the ways to miss: foreign
    // destination, short body, foreign target, length beyond the frame.
    build_ns(rand128(), our_unicast(), our_unicast(), 16'd24, 0);
    send_frame();
    build_ns(peer_addr(), our_link_local(), our_link_local(), 16'd24, 0);
    send_frame();
    build_ns('0, all_nodes(), our_unicast(), 16'd28, 4);
    send_frame();
    build_ns(rand128(), solicited_node(), our_link_local(), 16'd32, 8);
    send_frame();
    build_ns(rand128(), rand128(), our_unicast(), 16'd24, 0);
    send_frame();
    build_ns(rand128(), our_unicast(), our_unicast(), 16'd23, 0);
    send_frame();
    build_ns(rand128(), our_unicast(), flip_bit(our_unicast()), 16'd24, 0);
    send_frame();
    build_ns(rand128(), our_unicast(), our_unicast(), 16'd30, 2);
    send_frame();

    // All-one addresses, and data traffic that claims the ICMPv6 next header: the
    // ICMPv6 rules take precedence over delivery.
    settle();
    program_regs('1, '1, '1, '1, NH_ICMPV6);
    build_data(IP_VERSION, peer_addr(), our_unicast(), data_nh, 16'd8, 8);
    frame_q[40] = TypeEcho;
    send_frame();
    build_ns(peer_addr(), our_unicast(), our_link_local(), 16'd24, 0);
    send_frame();

    // Unicast equal to link-local: a target matches both, a link-local destination
    // is reported as unicast.
    settle();
    program_regs(LL_PREFIX, rand64(), '0, '0, 8'hFF);
    build_ns('0, our_link_local(), our_unicast(), 16'd24, 0);
    send_frame();
    build_data(IP_VERSION, '0, our_unicast(), data_nh, 16'd1, 1);
    send_frame();

    // Random traffic in three phases of idling: sender light and receiver heavy, then
    // the reverse, then none at all. Each phase starts with a fresh register setting,
    // which also changes after every dozen frames, and now and then the sender waits
    // for every verdict before going on.
    for (int ph = 0; ph < 3; ph++) begin
      int unsigned phase_beats, phase_frames;
      phase_beats  = beats_sent;
      phase_frames = 0;
      case (ph)
        0: begin
          tx_idle_pct = 10;
          rx_idle_pct = 51;
        end
        1: begin
          tx_idle_pct = 51;
          rx_idle_pct = 10;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      while (beats_sent - phase_beats < PhaseBeats) begin
        if (phase_frames % 12 == 0) begin
          settle();
          pick_setting();
        end
        case ($urandom_range(19))
          0, 1, 2, 3, 4, 5, 6: make_data_frame();
          7, 8, 9, 10, 11, 12, 13: make_ns_frame();
          14, 15: make_icmp_frame();
          16, 17: begin
            // Truncated header, sometimes with a plausible version.
            frame_q.delete();
            push_random($urandom_range(39, 1));
            if ($urandom_range(1) == 0) frame_q[0][7:4] = IP_VERSION;
          end
          default: begin
            frame_q.delete();
            push_random($urandom_range(90, 1));
          end
        endcase
        send_frame();
        phase_frames++;
        if ($urandom_range(19) == 0) settle();
      end
    end

    settle();
    $display("Run covered %0d frames, %0d byte beats (longest frame %0d bytes),",
             frames_sent, beats_sent, longest_frame);
    $display("%0d register settings and %0d verdict beats checked.",
             settings_used, verdicts_seen);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
